FILE: sv/lsfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfa_pkg
// Types and codes shared by the lockable slot allocator modules.
// ----------------------------------------------------------------------------
package lsfa_pkg;

    // Fixed field widths of the request and result items.
    localparam int REQ_W    = 4;
    localparam int INDEX_W  = 9;
    localparam int FIRST_W  = 32;
    localparam int SECOND_W = 31;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;

    // Request codes as they arrive on the input channel.
    localparam logic [REQ_W-1:0] REQ_ALLOC    = 4'd0;
    localparam logic [REQ_W-1:0] REQ_CLAIM    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_LOCK     = 4'd3;
    localparam logic [REQ_W-1:0] REQ_UNLOCK   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_READ     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_NEXTFREE = 4'd6;
    localparam logic [REQ_W-1:0] REQ_SETHEAD  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INUSE   = 3'd5;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [3:0] {
        OP_ALLOC,
        OP_CLAIM,
        OP_RELEASE,
        OP_LOCK,
        OP_UNLOCK,
        OP_READ,
        OP_NEXTFREE,
        OP_SETHEAD,
        OP_CLEAR,
        OP_BAD
    } op_t;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic [INDEX_W-1:0]  index;
        logic                in_range;
        logic                head_ok;
        logic                from_head;
        logic [FIRST_W-1:0]  first_arg;
        logic [SECOND_W-1:0] second_arg;
        logic                keep_locked;
    } q_ent_t;

    // One table slot. A free slot uses only its link.
    typedef struct packed {
        logic                valid;
        logic                lock;
        logic [FIRST_W-1:0]  first;
        logic [SECOND_W-1:0] second;
        logic [SLOT_W-1:0]   link;
    } slot_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_WSTART,
        BK_WALK
    } back_state_t;

endpackage

FILE: sv/lsfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfa_front
// Accepts requests, decodes and range checks them, and queues them for the
// back end.
// ----------------------------------------------------------------------------
module lsfa_front import lsfa_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                hold,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [INDEX_W-1:0]  s_index,
    input  logic                s_from_head,
    input  logic [FIRST_W-1:0]  s_first_arg,
    input  logic [SECOND_W-1:0] s_second_arg,
    input  logic                s_keep_locked,
    output logic                q_valid,
    output q_ent_t              q_data,
    input  logic                q_pop
);

    localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(DEPTH);

    q_ent_t              ent;
    q_ent_t              fifo [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push;

    always_comb begin
        case (s_req_type)
            REQ_ALLOC:    ent.op = OP_ALLOC;
            REQ_CLAIM:    ent.op = OP_CLAIM;
            REQ_RELEASE:  ent.op = OP_RELEASE;
            REQ_LOCK:     ent.op = OP_LOCK;
            REQ_UNLOCK:   ent.op = OP_UNLOCK;
            REQ_READ:     ent.op = OP_READ;
            REQ_NEXTFREE: ent.op = OP_NEXTFREE;
            REQ_SETHEAD:  ent.op = OP_SETHEAD;
            REQ_CLEAR:    ent.op = OP_CLEAR;
            default:      ent.op = OP_BAD;
        endcase
        ent.index       = s_index;
        ent.in_range    = {1'b0, s_index} < DEPTH_S;
        ent.head_ok     = {1'b0, s_index} <= DEPTH_S;
        ent.from_head   = s_from_head;
        ent.first_arg   = s_first_arg;
        ent.second_arg  = s_second_arg;
        ent.keep_locked = s_keep_locked;
    end

    assign s_ready = (cnt_reg != QCNT_W'(QDEPTH)) && !hold;
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != '0;
    assign q_data  = fifo[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo[wr_ptr_reg] <= ent;
        end
    end

endmodule

FILE: sv/lsfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfa_back
// Executes queued requests against the slot memory as read-modify-write
// steps, walks the table for clear and for the pass after reset, and holds
// the result register.
// ----------------------------------------------------------------------------
module lsfa_back import lsfa_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    output logic                init_busy,
    input  logic                q_valid,
    input  q_ent_t              q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_out,
    output logic                m_occupied,
    output logic                m_locked,
    output logic [FIRST_W-1:0]  m_first_out,
    output logic [SECOND_W-1:0] m_second_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(DEPTH);
    localparam logic [AW-1:0]     LAST_A  = AW'(DEPTH - 1);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;
    slot_t wr_data;
    logic  rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    back_state_t         state_reg, state_next;
    q_ent_t              item_reg, item_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   last_reg, last_next;
    logic [AW-1:0]       walk_reg, walk_next;
    logic                user_reg, user_next;
    logic                init_reg, init_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                occ_reg, occ_next;
    logic                lock_reg, lock_next;
    logic [FIRST_W-1:0]  first_reg, first_next;
    logic [SECOND_W-1:0] second_reg, second_next;

    logic  out_free;
    logic  emit;
    logic  head_in;
    logic  free_it;
    slot_t d;

    assign out_free = !out_valid_reg || m_ready;
    assign head_in  = head_reg < DEPTH_S;
    assign d        = rd_data_reg;
    assign free_it  = !user_reg || !item_reg.keep_locked || !d.valid || !d.lock;

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        head_next   = head_reg;
        last_next   = last_reg;
        walk_next   = walk_reg;
        user_next   = user_reg;
        init_next   = init_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = d;
        emit        = 1'b0;
        status_next = ST_OK;
        slot_next   = '0;
        occ_next    = 1'b0;
        lock_next   = 1'b0;
        first_next  = '0;
        second_next = '0;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_data;
                    if (q_data.op == OP_CLEAR) begin
                        user_next  = 1'b1;
                        state_next = BK_WSTART;
                    end else begin
                        state_next = BK_EXEC;
                        if (q_data.op == OP_ALLOC) begin
                            rd_en   = head_in;
                            rd_addr = head_reg[AW-1:0];
                        end else begin
                            rd_en   = q_data.in_range;
                            rd_addr = q_data.index[AW-1:0];
                        end
                    end
                end
            end

            BK_EXEC: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                    wr_addr    = item_reg.index[AW-1:0];
                    case (item_reg.op)
                        OP_ALLOC: begin
                            if (!head_in) begin
                                status_next = ST_FULL;
                                slot_next   = DEPTH_S;
                            end else if (d.valid) begin
                                status_next = ST_INUSE;
                                slot_next   = head_reg;
                            end else begin
                                wr_en          = 1'b1;
                                wr_addr        = head_reg[AW-1:0];
                                wr_data.valid  = 1'b1;
                                wr_data.lock   = 1'b0;
                                wr_data.first  = item_reg.first_arg;
                                wr_data.second = item_reg.second_arg;
                                head_next      = d.link;
                                slot_next      = head_reg;
                            end
                        end
                        OP_CLAIM: begin
                            if (!item_reg.in_range) begin
                                status_next = ST_RANGE;
                            end else if (d.valid) begin
                                status_next = ST_INUSE;
                            end else begin
                                wr_en          = 1'b1;
                                wr_data.valid  = 1'b1;
                                wr_data.lock   = 1'b0;
                                wr_data.first  = item_reg.first_arg;
                                wr_data.second = item_reg.second_arg;
                            end
                        end
                        OP_RELEASE: begin
                            if (!item_reg.in_range) begin
                                status_next = ST_RANGE;
                            end else if (!d.valid) begin
                                status_next = ST_EMPTY;
                            end else if (d.lock) begin
                                status_next = ST_REFUSED;
                            end else begin
                                wr_en          = 1'b1;
                                wr_data.valid  = 1'b0;
                                wr_data.lock   = 1'b0;
                                wr_data.first  = '0;
                                wr_data.second = '0;
                                wr_data.link   = head_reg;
                                head_next      = {1'b0, item_reg.index};
                            end
                        end
                        OP_LOCK, OP_UNLOCK: begin
                            if (!item_reg.in_range) begin
                                status_next = ST_RANGE;
                            end else if (!d.valid) begin
                                status_next = ST_EMPTY;
                            end else if (d.lock == (item_reg.op == OP_LOCK)) begin
                                status_next = ST_REFUSED;
                            end else begin
                                wr_en        = 1'b1;
                                wr_data.lock = item_reg.op == OP_LOCK;
                            end
                        end
                        OP_READ: begin
                            if (!item_reg.in_range) begin
                                status_next = ST_RANGE;
                            end else if (!d.valid) begin
                                status_next = ST_EMPTY;
                                slot_next   = d.link;
                            end else begin
                                occ_next    = 1'b1;
                                lock_next   = d.lock;
                                first_next  = d.first;
                                second_next = d.second;
                            end
                        end
                        OP_NEXTFREE: begin
                            if (item_reg.from_head) begin
                                slot_next = head_reg;
                            end else if (!item_reg.in_range) begin
                                status_next = ST_RANGE;
                                slot_next   = DEPTH_S;
                            end else if (d.valid) begin
                                status_next = ST_INUSE;
                                slot_next   = DEPTH_S;
                            end else begin
                                slot_next = d.link;
                            end
                        end
                        OP_SETHEAD: begin
                            if (!item_reg.head_ok) begin
                                status_next = ST_RANGE;
                            end else begin
                                head_next = {1'b0, item_reg.index};
                            end
                        end
                        default: begin
                            status_next = ST_REFUSED;
                        end
                    endcase
                end
            end

            BK_WSTART: begin
                rd_en      = 1'b1;
                rd_addr    = LAST_A;
                walk_next  = LAST_A;
                last_next  = DEPTH_S;
                state_next = BK_WALK;
            end

            BK_WALK: begin
                if ((walk_reg != '0) || !user_reg || out_free) begin
                    if (free_it) begin
                        wr_en          = 1'b1;
                        wr_addr        = walk_reg;
                        wr_data.valid  = 1'b0;
                        wr_data.lock   = 1'b0;
                        wr_data.first  = '0;
                        wr_data.second = '0;
                        wr_data.link   = last_reg;
                        last_next      = SLOT_W'(walk_reg);
                    end
                    if (walk_reg != '0) begin
                        walk_next = walk_reg - 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = walk_reg - 1'b1;
                    end else begin
                        head_next  = free_it ? SLOT_W'(walk_reg) : last_reg;
                        emit       = user_reg;
                        user_next  = 1'b0;
                        init_next  = 1'b0;
                        state_next = BK_IDLE;
                    end
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_WSTART;
            head_reg      <= '0;
            last_reg      <= '0;
            walk_reg      <= '0;
            user_reg      <= 1'b0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            last_reg      <= last_next;
            walk_reg      <= walk_next;
            user_reg      <= user_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (emit) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            occ_reg    <= occ_next;
            lock_reg   <= lock_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign init_busy    = init_reg;
    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_slot_out   = slot_reg;
    assign m_occupied   = occ_reg;
    assign m_locked     = lock_reg;
    assign m_first_out  = first_reg;
    assign m_second_out = second_reg;

endmodule

FILE: sv/lockable_slot_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockable_slot_free_list_allocator
// Slot table with an in-table free list, lockable occupied slots and a
// clear that rebuilds the free list in ascending order.
// ----------------------------------------------------------------------------
//
//   Channel   Ports   Carries
//   -------   -----   ----------------------------------------------------
//   request   s_*     req_type, index, from_head, first_arg, second_arg,
//                     keep_locked
//   result    m_*     status, slot_out, occupied, locked, first_out,
//                     second_out
//
// Each request except clear is a read-modify-write of one slot in a memory
// with a registered read port: the back end pops an item and reads its slot
// in BK_IDLE, then decides, writes the slot and the head register and loads
// the result register in BK_EXEC, and pops no new item before it is idle.
// A clear walks the table from the top slot down, one slot per cycle, with
// a stall only at the last slot while the result register is still full.
// After reset the same walk runs once without a result: s_ready stays low
// while every slot is freed and linked to the next one.
// A two-entry queue sits between the front and the back, and the result sits
// in its own register, so the front keeps taking items into free queue
// entries while a result waits on m_ready; the back end stalls only when it
// has a new result to load and the result register is still full.
//
module lockable_slot_free_list_allocator import lsfa_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [INDEX_W-1:0]  s_index,
    input  logic                s_from_head,
    input  logic [FIRST_W-1:0]  s_first_arg,
    input  logic [SECOND_W-1:0] s_second_arg,
    input  logic                s_keep_locked,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_out,
    output logic                m_occupied,
    output logic                m_locked,
    output logic [FIRST_W-1:0]  m_first_out,
    output logic [SECOND_W-1:0] m_second_out
);

    // Classified requests waiting for the back end.
    logic   q_valid;
    q_ent_t q_data;
    logic   q_pop;

    // High while the table is being initialized after reset.
    logic   init_busy;

    lsfa_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .hold          (init_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_index       (s_index),
        .s_from_head   (s_from_head),
        .s_first_arg   (s_first_arg),
        .s_second_arg  (s_second_arg),
        .s_keep_locked (s_keep_locked),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    lsfa_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .init_busy    (init_busy),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot_out   (m_slot_out),
        .m_occupied   (m_occupied),
        .m_locked     (m_locked),
        .m_first_out  (m_first_out),
        .m_second_out (m_second_out)
    );

endmodule
